FILE: rtl/core/mode_space_projection_mac_macros.svh
// assertion macros shared by the mode space projection mac rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef MODE_SPACE_PROJECTION_MAC_MACROS_SVH
`define MODE_SPACE_PROJECTION_MAC_MACROS_SVH

// property must hold at every clock edge outside reset
`define MSPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define MSPM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/core/mspm_pkg.sv
// shared types and constants of the mode space projection mac
// no dependencies; imported by every module of the block except mspm_ram
package mspm_pkg;

  localparam int unsigned MAX_ATOMS = 256;
  localparam int unsigned MAX_MODES = 768;
  localparam int unsigned ROW_DEPTH = 3 * MAX_ATOMS;
  localparam int unsigned ACC_DEPTH = (ROW_DEPTH > MAX_MODES) ? ROW_DEPTH : MAX_MODES;
  localparam int unsigned ACC_AW    = $clog2(ACC_DEPTH);
  localparam int unsigned ACC_W     = 64;

  localparam int unsigned ATOM_W   = 8;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned MODE_W   = 10;
  localparam int unsigned TGT_W    = 10;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned RND_W    = 34;
  localparam int unsigned ROW_W    = TGT_W + 1;
  localparam int unsigned CMP_W    = 16;
  localparam int unsigned ACNT_W   = 9;
  localparam int unsigned MCNT_W   = 10;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_DIRECTION  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATOM_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE_COUNT = 2'd2;

  localparam logic DIR_EXPAND  = 1'b0;
  localparam logic DIR_PROJECT = 1'b1;

  localparam logic signed [DATA_W-1:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SUM_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0]  ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [ACC_W-1:0]  ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [PROD_W-1:0] RND_HALF = 64'sh0000_0000_2000_0000;

  typedef struct packed {
    logic              direction;
    logic [ACNT_W-1:0] atom_count;
    logic [MCNT_W-1:0] mode_count;
  } cfg_t;

  typedef struct packed {
    logic [TGT_W-1:0]         target;
    logic signed [DATA_W-1:0] coefficient;
    logic signed [DATA_W-1:0] operand;
    logic                     first;
    logic                     err;
  } item_t;

  typedef struct packed {
    logic [TGT_W-1:0] target;
    logic             first;
    logic             err;
  } tag_t;

  typedef struct packed {
    logic [TGT_W-1:0]         target_index;
    logic signed [DATA_W-1:0] sum;
    logic                     saturated;
    logic                     index_error;
  } result_t;

endpackage

FILE: rtl/core/mspm_ram.sv
// generic single write port ram with registered read port
// no dependencies
module mspm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mspm_front.sv
// front end: takes requests, checks indices and picks the accumulator
// depends on mspm_pkg
module mspm_front (
  input  mspm_pkg::cfg_t                      cfg_i,
  input  logic                                push_i,
  input  logic                                full_i,
  input  logic [mspm_pkg::ATOM_W-1:0]         atom_i,
  input  logic [mspm_pkg::AXIS_W-1:0]         axis_i,
  input  logic [mspm_pkg::MODE_W-1:0]         mode_index_i,
  input  logic signed [mspm_pkg::DATA_W-1:0]  coefficient_i,
  input  logic signed [mspm_pkg::DATA_W-1:0]  operand_i,
  input  logic                                first_i,
  output logic                                q_push_o,
  output mspm_pkg::item_t                     q_entry_o
);
  import mspm_pkg::*;

  logic             axis_ok;
  logic             atom_ok;
  logic             mode_ok;
  logic             row_ok;
  logic             valid;
  logic [ROW_W-1:0] row;

  always_comb begin
    axis_ok = (axis_i <= AXIS_W'(2));
    atom_ok = (CMP_W'(atom_i) < CMP_W'(cfg_i.atom_count)) &&
              (CMP_W'(atom_i) < CMP_W'(MAX_ATOMS));
    mode_ok = (CMP_W'(mode_index_i) < CMP_W'(cfg_i.mode_count)) &&
              (CMP_W'(mode_index_i) < CMP_W'(MAX_MODES));
    row     = ROW_W'({atom_i, 1'b0}) + ROW_W'(atom_i) + ROW_W'(axis_i);
    row_ok  = (cfg_i.direction == DIR_PROJECT) || (CMP_W'(row) < CMP_W'(ACC_DEPTH));
    valid   = axis_ok && atom_ok && mode_ok && row_ok;

    q_entry_o.coefficient = coefficient_i;
    q_entry_o.operand     = operand_i;
    q_entry_o.first       = first_i;
    q_entry_o.err         = !valid;
    if (!valid) begin
      q_entry_o.target = '0;
    end else if (cfg_i.direction == DIR_PROJECT) begin
      q_entry_o.target = TGT_W'(mode_index_i);
    end else begin
      q_entry_o.target = row[TGT_W-1:0];
    end
  end

  assign q_push_o = push_i && !full_i;

endmodule

FILE: rtl/core/mspm_queue.sv
// small request queue between front end and accumulate pipeline
// depends on mspm_pkg and the assertion macro header
`include "mode_space_projection_mac_macros.svh"

module mspm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mspm_pkg::item_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output mspm_pkg::item_t head_o,
  output logic            valid_o
);
  import mspm_pkg::*;

  item_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  `MSPM_ASSERT(a_count_bound, count_q <= QCNT_W'(QDEPTH), "queue count above depth")
  `MSPM_ASSERT(a_push_grows, (do_push && !do_pop) |=> (count_q == $past(count_q) + QCNT_W'(1)), "queue count did not grow on push")
  `MSPM_ASSERT_NEVER(a_pop_empty, pop_i && (count_q == '0), "pop from empty queue")

endmodule

FILE: rtl/core/mspm_back.sv
// accumulate pipeline: multiply, round, read-modify-write of accumulators
// depends on mspm_pkg, mspm_ram and the assertion macro header
`include "mode_space_projection_mac_macros.svh"

module mspm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mspm_pkg::item_t   head_i,
  input  logic              head_valid_i,
  output logic              head_pop_o,
  output mspm_pkg::result_t result_o,
  output logic              empty_o,
  input  logic              pop_i
);
  import mspm_pkg::*;

  logic                     adv;
  logic                     s1_valid_q, s1_valid_d;
  tag_t                     s1_tag_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     s2_valid_q, s2_valid_d;
  tag_t                     s2_tag_q;
  logic signed [RND_W-1:0]  rnd_q, rnd_d;
  logic signed [PROD_W-1:0] rnd_sum;
  logic                     out_valid_q, out_valid_d;
  result_t                  out_q, out_d;
  logic                     wb_valid_q, wb_valid_d;
  logic [TGT_W-1:0]         wb_addr_q;
  logic [ACC_W-1:0]         wb_data_q;
  logic                     rd_en;
  logic                     wr_en;
  logic [ACC_W-1:0]         acc_rd;
  logic signed [ACC_W-1:0]  acc_old;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W:0]    sum_wide;
  logic signed [ACC_W-1:0]  acc_new;
  logic [ACC_W-DATA_W:0]    acc_hi;

  assign adv        = !out_valid_q || pop_i;
  assign head_pop_o = adv && head_valid_i;
  assign rd_en      = adv && s1_valid_q && !s1_tag_q.err;
  assign wr_en      = adv && s2_valid_q && !s2_tag_q.err;
  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;

  mspm_ram #(
    .WIDTH(ACC_W),
    .DEPTH(ACC_DEPTH)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s2_tag_q.target[ACC_AW-1:0]),
    .wdata_i(acc_new),
    .re_i   (rd_en),
    .raddr_i(s1_tag_q.target[ACC_AW-1:0]),
    .rdata_o(acc_rd)
  );

  always_comb begin
    prod_d  = head_i.coefficient * head_i.operand;
    rnd_sum = prod_q + RND_HALF;
    rnd_d   = rnd_sum[PROD_W-1:PROD_W-RND_W];

    // bypass the write made at the same edge as this entry's read
    if (wb_valid_q && (wb_addr_q == s2_tag_q.target)) begin
      acc_old = wb_data_q;
    end else begin
      acc_old = acc_rd;
    end
    acc_base = s2_tag_q.first ? '0 : acc_old;
    sum_wide = {acc_base[ACC_W-1], acc_base} + {{(ACC_W + 1 - RND_W){rnd_q[RND_W-1]}}, rnd_q};
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      acc_new = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_new = sum_wide[ACC_W-1:0];
    end
    acc_hi = acc_new[ACC_W-1:DATA_W-1];

    out_d = '0;
    if (s2_tag_q.err) begin
      out_d.index_error = 1'b1;
    end else begin
      out_d.target_index = s2_tag_q.target;
      if ((&acc_hi) || !(|acc_hi)) begin
        out_d.sum = acc_new[DATA_W-1:0];
      end else begin
        out_d.saturated = 1'b1;
        out_d.sum       = acc_new[ACC_W-1] ? SUM_MIN : SUM_MAX;
      end
    end

    s1_valid_d  = adv ? head_valid_i : s1_valid_q;
    s2_valid_d  = adv ? s1_valid_q : s2_valid_q;
    out_valid_d = adv ? s2_valid_q : out_valid_q;
    wb_valid_d  = wr_en ? 1'b1 : wb_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wb_valid_q  <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      wb_valid_q  <= wb_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q.target <= head_i.target;
      s1_tag_q.first  <= head_i.first;
      s1_tag_q.err    <= head_i.err;
      prod_q          <= prod_d;
      s2_tag_q        <= s1_tag_q;
      rnd_q           <= rnd_d;
      out_q           <= out_d;
    end
    if (wr_en) begin
      wb_addr_q <= s2_tag_q.target;
      wb_data_q <= acc_new;
    end
  end

  `MSPM_ASSERT(a_err_zero, (out_valid_q && out_q.index_error) |-> ((out_q.sum == '0) && !out_q.saturated && (out_q.target_index == '0)), "rejected result carries data")
  `MSPM_ASSERT(a_sat_limit, (out_valid_q && out_q.saturated) |-> ((out_q.sum == SUM_MAX) || (out_q.sum == SUM_MIN)), "saturated sum not at a limit")
  `MSPM_ASSERT(a_stall_hold, (s2_valid_q && !adv) |=> (s2_valid_q && $stable(s2_tag_q) && $stable(rnd_q)), "accumulate stage moved during stall")

endmodule

FILE: rtl/core/mode_space_projection_mac.sv
// top level of the mode space projection mac: register port and block wiring
// depends on mspm_pkg, mspm_front, mspm_queue and mspm_back
//
// Each request carries one basis matrix element and one operand; the block
// multiplies them, rounds the Q17.46 product to Q16.16 and adds it into a
// 64-bit accumulator chosen by the mode (project) or by row 3*atom+axis
// (expand), returning the updated sum clipped to 32 bits. One request is
// taken every clock cycle while the result side is not stalled, passing
// through the product, rounding and result registers. Rate is set by the single
// 768-entry accumulator memory, which does one read and one write per cycle
// with a one-deep write-back bypass, and by the one 32x32 multiplier stage.
// A four-entry queue behind the input lets requests keep coming while a
// result waits to be popped. Accumulators are not cleared at reset: the
// first flag of a request starts its accumulator from zero. Configuration
// registers sit at byte addresses 0 (direction), 4 (atom count) and
// 8 (mode count) and should be written only while the block is idle.
module mode_space_projection_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mspm_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                push,
  output logic                                full,
  input  logic [mspm_pkg::ATOM_W-1:0]         atom_i,
  input  logic [mspm_pkg::AXIS_W-1:0]         axis_i,
  input  logic [mspm_pkg::MODE_W-1:0]         mode_index_i,
  input  logic signed [mspm_pkg::DATA_W-1:0]  coefficient_i,
  input  logic signed [mspm_pkg::DATA_W-1:0]  operand_i,
  input  logic                                first_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [mspm_pkg::TGT_W-1:0]          target_index_o,
  output logic signed [mspm_pkg::DATA_W-1:0]  sum_o,
  output logic                                saturated_o,
  output logic                                index_error_o
);
  import mspm_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 q_push;
  item_t                q_entry;
  logic                 q_full;
  item_t                q_head;
  logic                 q_valid;
  logic                 q_pop;
  result_t              result;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    case (reg_idx)
      REG_DIRECTION: begin
        prdata = 32'(cfg_q.direction);
        if (cfg_wr) cfg_d.direction = pwdata[0];
      end
      REG_ATOM_COUNT: begin
        prdata = 32'(cfg_q.atom_count);
        if (cfg_wr) cfg_d.atom_count = pwdata[ACNT_W-1:0];
      end
      REG_MODE_COUNT: begin
        prdata = 32'(cfg_q.mode_count);
        if (cfg_wr) cfg_d.mode_count = pwdata[MCNT_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction  <= DIR_PROJECT;
      cfg_q.atom_count <= ACNT_W'(256);
      cfg_q.mode_count <= MCNT_W'(768);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mspm_front u_front (
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_i       (q_full),
    .atom_i       (atom_i),
    .axis_i       (axis_i),
    .mode_index_i (mode_index_i),
    .coefficient_i(coefficient_i),
    .operand_i    (operand_i),
    .first_i      (first_i),
    .q_push_o     (q_push),
    .q_entry_o    (q_entry)
  );

  mspm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head),
    .valid_o(q_valid)
  );

  mspm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .head_valid_i(q_valid),
    .head_pop_o  (q_pop),
    .result_o    (result),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign full           = q_full;
  assign target_index_o = result.target_index;
  assign sum_o          = result.sum;
  assign saturated_o    = result.saturated;
  assign index_error_o  = result.index_error;

endmodule

FILE: tb/mode_space_projection_mac_test.sv
// self-checking testbench of the mode space projection mac: directed and random requests,
// a shadow accumulator memory predicts every result, register writes over the apb port
// depends on mspm_pkg and mode_space_projection_mac
module mode_space_projection_mac_test;
  import mspm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 100;
  localparam int unsigned DRAIN_WAIT  = 6;

  typedef struct packed {
    logic [ATOM_W-1:0]        atom;
    logic [AXIS_W-1:0]        axis;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] coefficient;
    logic signed [DATA_W-1:0] operand;
    logic                     first;
  } mac_req_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     push;
  logic                     full;
  logic [ATOM_W-1:0]        atom_i;
  logic [AXIS_W-1:0]        axis_i;
  logic [MODE_W-1:0]        mode_index_i;
  logic signed [DATA_W-1:0] coefficient_i;
  logic signed [DATA_W-1:0] operand_i;
  logic                     first_i;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [TGT_W-1:0]         target_index_o;
  logic signed [DATA_W-1:0] sum_o;
  logic                     saturated_o;
  logic                     index_error_o;

  // shadow of the block state
  logic signed [ACC_W-1:0] acc_shadow [ACC_DEPTH];
  bit                      started [ACC_DEPTH];
  logic                    cfg_dir;
  logic [ACNT_W-1:0]       cfg_atoms;
  logic [MCNT_W-1:0]       cfg_modes;

  result_t     sums_due[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count;
  bit          send_gaps;
  bit          pop_gaps;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  mode_space_projection_mac DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .atom_i         (atom_i),
    .axis_i         (axis_i),
    .mode_index_i   (mode_index_i),
    .coefficient_i  (coefficient_i),
    .operand_i      (operand_i),
    .first_i        (first_i),
    .empty          (empty),
    .pop            (pop),
    .target_index_o (target_index_o),
    .sum_o          (sum_o),
    .saturated_o    (saturated_o),
    .index_error_o  (index_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned live_atoms();
    return (cfg_atoms < MAX_ATOMS) ? cfg_atoms : MAX_ATOMS;
  endfunction

  function automatic int unsigned live_modes();
    return (cfg_modes < MAX_MODES) ? cfg_modes : MAX_MODES;
  endfunction

  function automatic int unsigned target_of(mac_req_t r);
    return (cfg_dir == DIR_PROJECT) ? int'(r.mode) : 3 * int'(r.atom) + int'(r.axis);
  endfunction

  function automatic result_t accumulate_product(mac_req_t r);
    result_t            res;
    logic signed [63:0] c64;
    logic signed [63:0] o64;
    logic signed [63:0] rounded;
    logic signed [63:0] base;
    logic signed [63:0] acc;
    logic signed [64:0] a65;
    logic signed [64:0] r65;
    logic signed [64:0] s65;
    int unsigned        tgt;
    res = '0;
    if (r.axis > 2 || r.atom >= live_atoms() || r.mode >= live_modes()) begin
      res.index_error = 1'b1;
      return res;
    end
    tgt = target_of(r);
    c64 = 64'(r.coefficient);
    o64 = 64'(r.operand);
    // round half up from q17.46 to q16.16
    rounded = (c64 * o64 + 64'sh2000_0000) >>> 30;
    base = r.first ? 64'sd0 : acc_shadow[tgt];
    a65 = 65'(base);
    r65 = 65'(rounded);
    s65 = a65 + r65;
    if (s65[64] != s65[63]) begin
      acc = s65[64] ? ACC_MIN : ACC_MAX;
    end else begin
      acc = s65[63:0];
    end
    acc_shadow[tgt] = acc;
    started[tgt] = 1'b1;
    res.target_index = TGT_W'(tgt);
    if (acc > SUM_MAX) begin
      res.sum = SUM_MAX;
      res.saturated = 1'b1;
    end else if (acc < SUM_MIN) begin
      res.sum = SUM_MIN;
      res.saturated = 1'b1;
    end else begin
      res.sum = acc[31:0];
    end
    return res;
  endfunction

  function automatic mac_req_t mac_request(int unsigned atom, int unsigned axis,
                                           int unsigned mode, logic signed [31:0] coef,
                                           logic signed [31:0] opnd, bit first);
    mac_req_t r;
    r.atom = ATOM_W'(atom);
    r.axis = AXIS_W'(axis);
    r.mode = MODE_W'(mode);
    r.coefficient = coef;
    r.operand = opnd;
    r.first = first;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_q();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
      3: begin
        case ($urandom_range(0, 5))
          0: return SUM_MAX;
          1: return SUM_MIN;
          2: return 32'sd0;
          3: return 32'sd1;
          4: return -32'sd1;
          default: return 32'sh4000_0000;
        endcase
      end
      4: begin
        v = 32'sd1 <<< $urandom_range(0, 30);
        return $urandom_range(0, 1) ? -v : v;
      end
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic void make_request(output mac_req_t r, input int unsigned bad_pct);
    int unsigned na;
    int unsigned nm;
    na = live_atoms();
    nm = live_modes();
    r.coefficient = pick_q();
    r.operand = pick_q();
    r.first = $urandom_range(0, 99) < 15;
    if (na == 0 || nm == 0 || $urandom_range(0, 99) < bad_pct) begin
      r.atom = ATOM_W'($urandom);
      r.axis = AXIS_W'($urandom);
      r.mode = MODE_W'($urandom);
      case ($urandom_range(0, 2))
        0: r.axis = 2'd3;
        1: begin
          if (na < 256) begin
            r.atom = ATOM_W'($urandom_range(na, 255));
          end else begin
            r.axis = 2'd3;
          end
        end
        default: r.mode = MODE_W'($urandom_range(nm, 1023));
      endcase
    end else begin
      // half the time stay on a few targets so sums build up
      if ($urandom_range(0, 1)) begin
        r.atom = ATOM_W'($urandom_range(0, ((na < 4) ? na : 4) - 1));
        r.mode = MODE_W'($urandom_range(0, ((nm < 8) ? nm : 8) - 1));
      end else begin
        r.atom = ATOM_W'($urandom_range(0, na - 1));
        r.mode = MODE_W'($urandom_range(0, nm - 1));
      end
      r.axis = AXIS_W'($urandom_range(0, 2));
      if (!started[target_of(r)]) begin
        r.first = 1'b1;
      end
    end
  endfunction

  task automatic send_request(input mac_req_t r);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push <= 1'b1;
    atom_i <= r.atom;
    axis_i <= r.axis;
    mode_index_i <= r.mode;
    coefficient_i <= r.coefficient;
    operand_i <= r.operand;
    first_i <= r.first;
    do @(posedge clk_i); while (full);
    sums_due.push_back(accumulate_product(r));
  endtask

  task automatic finish_stream();
    push <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_config(input logic dir, input int unsigned atoms, input int unsigned modes);
    logic [31:0]          value [3];
    logic [REG_IDX_W-1:0] reg_idx [3];
    value[0] = 32'(dir);
    value[1] = atoms;
    value[2] = modes;
    reg_idx = '{REG_DIRECTION, REG_ATOM_COUNT, REG_MODE_COUNT};
    for (int k = 0; k < 3; k++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx[k], 2'b00};
      pwdata <= value[k];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_dir = dir;
    cfg_atoms = ACNT_W'(atoms);
    cfg_modes = MCNT_W'(modes);
  endtask

  task automatic test_project_directed();
    set_config(DIR_PROJECT, 256, 768);
    send_request(mac_request(0, 0, 0, 32'sh4000_0000, 32'sh0001_0000, 1'b1));
    send_request(mac_request(0, 0, 0, 32'sh4000_0000, 32'sh0001_0000, 1'b0));
    send_request(mac_request(255, 2, 767, SUM_MAX, SUM_MAX, 1'b1));
    send_request(mac_request(255, 2, 767, SUM_MIN, SUM_MAX, 1'b0));
    send_request(mac_request(1, 1, 1, SUM_MIN, SUM_MIN, 1'b1));
    send_request(mac_request(2, 0, 2, SUM_MIN, SUM_MAX, 1'b1));
    // exact half steps of the rounding
    send_request(mac_request(3, 0, 3, 32'sd1, 32'sh2000_0000, 1'b1));
    send_request(mac_request(4, 0, 4, -32'sd1, 32'sh2000_0000, 1'b1));
    send_request(mac_request(5, 0, 5, 32'sd1, -32'sh2000_0001, 1'b1));
    send_request(mac_request(0, 3, 6, 32'sd1, 32'sd1, 1'b1));
    send_request(mac_request(0, 0, 768, 32'sd1, 32'sd1, 1'b1));
    send_request(mac_request(0, 0, 1023, 32'sd1, 32'sd1, 1'b0));
    send_request(mac_request(0, 0, 0, 32'sd0, SUM_MAX, 1'b1));
    finish_stream();
  endtask

  task automatic test_expand_directed();
    set_config(DIR_EXPAND, 256, 768);
    send_request(mac_request(255, 2, 767, 32'sh4000_0000, 32'sh0003_8000, 1'b1));
    send_request(mac_request(0, 0, 0, 32'sh4000_0000, -32'sh0001_0000, 1'b1));
    send_request(mac_request(0, 0, 5, 32'sh2000_0000, -32'sh0001_0000, 1'b0));
    send_request(mac_request(85, 1, 0, SUM_MAX, SUM_MIN, 1'b1));
    send_request(mac_request(10, 3, 0, 32'sd1, 32'sd1, 1'b1));
    send_request(mac_request(0, 0, 768, 32'sd1, 32'sd1, 1'b1));
    finish_stream();
  endtask

  task automatic test_count_limits();
    set_config(DIR_PROJECT, 1, 1);
    send_request(mac_request(0, 0, 0, 32'sh0800_0000, 32'sh0002_0000, 1'b1));
    send_request(mac_request(1, 0, 0, 32'sd1, 32'sd1, 1'b0));
    send_request(mac_request(0, 0, 1, 32'sd1, 32'sd1, 1'b0));
    send_request(mac_request(0, 3, 0, 32'sd1, 32'sd1, 1'b0));
    finish_stream();
    // a zero count rejects everything
    set_config(DIR_EXPAND, 0, 768);
    send_request(mac_request(0, 0, 0, 32'sd1, 32'sd1, 1'b1));
    finish_stream();
    set_config(DIR_PROJECT, 256, 0);
    send_request(mac_request(0, 0, 0, 32'sd1, 32'sd1, 1'b1));
    finish_stream();
    // counts above the sizes are clipped
    set_config(DIR_EXPAND, 511, 1023);
    send_request(mac_request(255, 2, 5, 32'sh4000_0000, 32'sh0000_8000, 1'b1));
    send_request(mac_request(0, 0, 768, 32'sd1, 32'sd1, 1'b1));
    send_request(mac_request(0, 0, 1023, 32'sd1, 32'sd1, 1'b1));
    finish_stream();
    set_config(DIR_PROJECT, 511, 1023);
    send_request(mac_request(255, 2, 767, 32'sh4000_0000, 32'sh0000_8000, 1'b1));
    send_request(mac_request(255, 2, 768, 32'sd1, 32'sd1, 1'b1));
    finish_stream();
  endtask

  task automatic test_full_backpressure();
    mac_req_t r;
    set_config(DIR_PROJECT, 256, 768);
    hold_req = 1'b1;
    repeat (40) begin
      make_request(r, 10);
      send_request(r);
    end
    finish_stream();
  endtask

  task automatic test_random_phases();
    mac_req_t r;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(DIR_PROJECT, 256, 768);
        1: set_config(DIR_EXPAND, 256, 768);
        2: set_config(DIR_EXPAND, 1, 1);
        3: set_config(1'($urandom_range(0, 1)), $urandom_range(1, 256), $urandom_range(1, 768));
        4: set_config(1'($urandom_range(0, 1)), $urandom_range(0, 511), $urandom_range(0, 1023));
        5: set_config(DIR_PROJECT, 511, 1023);
        6: set_config(1'($urandom_range(0, 1)), $urandom_range(1, 256), $urandom_range(1, 768));
        default: begin
          set_config(DIR_EXPAND, 256, 768);
          send_gaps = 1'b0;
          pop_gaps = 1'b0;
        end
      endcase
      repeat (200) begin
        make_request(r, 10);
        send_request(r);
      end
      finish_stream();
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (pop_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (sums_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request waiting, expected none actual target %h sum %h",
                 $time, target_index_o, sum_o);
      end else begin
        want = sums_due.pop_front();
        check_field("target_index", 32'(want.target_index), 32'(target_index_o));
        check_field("sum", want.sum, sum_o);
        check_field("saturated", 32'(want.saturated), 32'(saturated_o));
        check_field("index_error", 32'(want.index_error), 32'(index_error_o));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    push <= 1'b0;
    atom_i <= '0;
    axis_i <= '0;
    mode_index_i <= '0;
    coefficient_i <= '0;
    operand_i <= '0;
    first_i <= 1'b0;
    send_gaps = 1'b1;
    pop_gaps = 1'b1;
    cfg_dir = DIR_PROJECT;
    cfg_atoms = ACNT_W'(256);
    cfg_modes = MCNT_W'(768);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_project_directed();
    test_expand_directed();
    test_count_limits();
    test_full_backpressure();
    test_random_phases();
    if (mismatches == 0 && sums_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
